### src/ppi_pkg.sv
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types, constants and helpers for the particle pool integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package ppi_pkg;

    localparam int PARTICLE_SLOTS_DEF = 32;
    localparam int IN_DATA_W          = 240;
    localparam int OUT_DATA_W         = 72;
    localparam int OUT_USER_W         = 2;
    localparam int CFG_DATA_W         = 16;
    localparam int CFG_INDEX_W        = 1;

    // Opcode values carried in the input tuser
    localparam logic OP_SPAWN = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Register indexes on the write port
    localparam logic [CFG_INDEX_W-1:0] REG_DAMPING = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE  = 1'b1;

    localparam logic [15:0] DAMP_ONE    = 16'd32768;
    localparam logic [5:0]  ACTIVE_RST  = 6'd32;

    // One pool slot as held in the slot memory
    typedef struct packed {
        logic [31:0] age;
        logic [31:0] life;
        logic [31:0] acc_y;
        logic [31:0] acc_x;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } entry_t;

    // Decoded command from the front end
    typedef struct packed {
        logic        is_tick;
        logic [15:0] dt;
        logic [31:0] life;
        logic [31:0] acc_y;
        logic [31:0] acc_x;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } cmd_t;

    // One result word before packing
    typedef struct packed {
        logic [4:0]  slot;
        logic        alive;
        logic [31:0] px;
        logic [31:0] py;
        logic        full;
        logic        last;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHK,
        ST_RD,
        ST_A,
        ST_B,
        ST_C,
        ST_D,
        ST_E,
        ST_EMIT
    } state_t;

    // Saturate a 34-bit signed sum to 32 bits
    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)
            r = 32'h7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### src/ppi_front.sv
// ----------------------------------------------------------------------------
// ppi_front
// Accepts input words, decodes them into commands and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ppi_front
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [ppi_pkg::IN_DATA_W-1:0]      s_tdata,  // pos_x,pos_y,vel_x,vel_y,acc_x,acc_y,life_span,time_step
    input  wire                                s_tuser,  // opcode
    output logic                               cmd_valid,
    output ppi_pkg::cmd_t                      cmd,
    input  wire                                cmd_pop
);

    ppi_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    ppi_pkg::cmd_t dec;
    logic          push;
    logic          pop;

    // Decode one input word
    always_comb
    begin
        dec.is_tick = (s_tuser == ppi_pkg::OP_TICK);
        dec.pos_x   = s_tdata[31:0];
        dec.pos_y   = s_tdata[63:32];
        dec.vel_x   = s_tdata[95:64];
        dec.vel_y   = s_tdata[127:96];
        dec.acc_x   = s_tdata[159:128];
        dec.acc_y   = s_tdata[191:160];
        dec.life    = s_tdata[223:192];
        dec.dt      = s_tdata[239:224];
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    // Queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

### src/ppi_back.sv
// ----------------------------------------------------------------------------
// ppi_back
// Executes spawn and tick commands against the slot memory, one slot at a
// time, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppi_back
#(
    parameter int PARTICLE_SLOTS = ppi_pkg::PARTICLE_SLOTS_DEF,
    localparam int IDX_W = (PARTICLE_SLOTS > 1) ? $clog2(PARTICLE_SLOTS) : 1
)
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cmd_valid,
    input  wire  ppi_pkg::cmd_t                cmd,
    output logic                               cmd_pop,
    input  wire  [15:0]                        damp_eff,
    input  wire  [IDX_W-1:0]                   last_slot,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [ppi_pkg::OUT_DATA_W-1:0]     m_tdata,  // slot_index,out_pos_x,out_pos_y
    output logic [ppi_pkg::OUT_USER_W-1:0]     m_tuser,  // slot_alive,pool_full
    output logic                               m_tlast
);

    ppi_pkg::state_t state_reg, state_next;
    ppi_pkg::cmd_t   cmd_reg, cmd_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [PARTICLE_SLOTS-1:0] alive_reg, alive_next;
    ppi_pkg::res_t   res_reg, res_next;

    // Slot memory
    ppi_pkg::entry_t mem [PARTICLE_SLOTS];
    ppi_pkg::entry_t rd_reg;
    logic            mem_we;
    ppi_pkg::entry_t mem_wdata;

    // Datapath registers
    logic [31:0]         clk_reg, clk_next;
    logic                retire_reg, retire_next;
    logic signed [48:0]  adt_x_reg, adt_x_next, adt_y_reg, adt_y_next;
    logic [31:0]         v_x_reg, v_x_next, v_y_reg, v_y_next;
    logic signed [48:0]  vdp_x_reg, vdp_x_next, vdp_y_reg, vdp_y_next;
    logic [31:0]         vd_x_reg, vd_x_next, vd_y_reg, vd_y_next;
    logic signed [48:0]  vdt_x_reg, vdt_x_next, vdt_y_reg, vdt_y_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    ppi_pkg::res_t       out_reg, out_next;

    logic signed [16:0]  dt_s;
    logic signed [16:0]  damp_s;
    logic [32:0]         age_sum;
    logic [31:0]         vd_x_w, vd_y_w;
    logic [6:0]          idx_wide;

    assign dt_s     = $signed({1'b0, cmd_reg.dt});
    assign damp_s   = $signed({1'b0, damp_eff});
    assign age_sum  = {1'b0, rd_reg.age} + {17'd0, cmd_reg.dt};
    assign vd_x_w   = 32'(vdp_x_reg >>> 15);
    assign vd_y_w   = 32'(vdp_y_reg >>> 15);
    assign idx_wide = 7'(idx_reg);

    // Sequencer and datapath
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        idx_next       = idx_reg;
        alive_next     = alive_reg;
        res_next       = res_reg;
        clk_next       = clk_reg;
        retire_next    = retire_reg;
        adt_x_next     = adt_x_reg;
        adt_y_next     = adt_y_reg;
        v_x_next       = v_x_reg;
        v_y_next       = v_y_reg;
        vdp_x_next     = vdp_x_reg;
        vdp_y_next     = vdp_y_reg;
        vd_x_next      = vd_x_reg;
        vd_y_next      = vd_y_reg;
        vdt_x_next     = vdt_x_reg;
        vdt_y_next     = vdt_y_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_wdata      = rd_reg;

        unique case (state_reg)
            ppi_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    idx_next   = '0;
                    state_next = cmd.is_tick ? ppi_pkg::ST_CHK : ppi_pkg::ST_SCAN;
                end
            end

            // Spawn: look for the lowest free slot
            ppi_pkg::ST_SCAN:
            begin
                if (!alive_reg[idx_reg])
                begin
                    mem_we          = 1'b1;
                    mem_wdata.pos_x = cmd_reg.pos_x;
                    mem_wdata.pos_y = cmd_reg.pos_y;
                    mem_wdata.vel_x = cmd_reg.vel_x;
                    mem_wdata.vel_y = cmd_reg.vel_y;
                    mem_wdata.acc_x = cmd_reg.acc_x;
                    mem_wdata.acc_y = cmd_reg.acc_y;
                    mem_wdata.life  = cmd_reg.life;
                    mem_wdata.age   = '0;
                    alive_next[idx_reg] = 1'b1;
                    res_next   = '{slot: idx_wide[4:0], alive: 1'b1, px: cmd_reg.pos_x,
                                  py: cmd_reg.pos_y, full: 1'b0, last: 1'b1};
                    state_next = ppi_pkg::ST_EMIT;
                end
                else if (idx_reg == last_slot)
                begin
                    res_next   = '{slot: 5'd0, alive: 1'b0, px: 32'd0, py: 32'd0,
                                  full: 1'b1, last: 1'b1};
                    state_next = ppi_pkg::ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // Tick: dead slots report at once, live ones go to the datapath
            ppi_pkg::ST_CHK:
            begin
                if (!alive_reg[idx_reg])
                begin
                    res_next   = '{slot: idx_wide[4:0], alive: 1'b0, px: 32'd0, py: 32'd0,
                                  full: 1'b0, last: (idx_reg == last_slot)};
                    state_next = ppi_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = ppi_pkg::ST_RD;
                end
            end

            // Slot entry is being read
            ppi_pkg::ST_RD:
            begin
                state_next = ppi_pkg::ST_A;
            end

            // Age the slot, start acceleration products
            ppi_pkg::ST_A:
            begin
                clk_next    = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
                retire_next = (clk_next > rd_reg.life);
                adt_x_next  = 49'($signed(rd_reg.acc_x) * dt_s);
                adt_y_next  = 49'($signed(rd_reg.acc_y) * dt_s);
                state_next  = ppi_pkg::ST_B;
            end

            // Retire, or update velocity
            ppi_pkg::ST_B:
            begin
                if (retire_reg)
                begin
                    mem_we              = 1'b1;
                    mem_wdata.age       = clk_reg;
                    alive_next[idx_reg] = 1'b0;
                    res_next   = '{slot: idx_wide[4:0], alive: 1'b0, px: 32'd0, py: 32'd0,
                                  full: 1'b0, last: (idx_reg == last_slot)};
                    state_next = ppi_pkg::ST_EMIT;
                end
                else
                begin
                    v_x_next   = ppi_pkg::sat32(34'($signed(rd_reg.vel_x)) +
                                                34'(adt_x_reg >>> 16));
                    v_y_next   = ppi_pkg::sat32(34'($signed(rd_reg.vel_y)) +
                                                34'(adt_y_reg >>> 16));
                    state_next = ppi_pkg::ST_C;
                end
            end

            // Damping product
            ppi_pkg::ST_C:
            begin
                vdp_x_next = 49'($signed(v_x_reg) * damp_s);
                vdp_y_next = 49'($signed(v_y_reg) * damp_s);
                state_next = ppi_pkg::ST_D;
            end

            // Damped velocity and its step product
            ppi_pkg::ST_D:
            begin
                vd_x_next  = vd_x_w;
                vd_y_next  = vd_y_w;
                vdt_x_next = 49'($signed(vd_x_w) * dt_s);
                vdt_y_next = 49'($signed(vd_y_w) * dt_s);
                state_next = ppi_pkg::ST_E;
            end

            // Position update and write back
            ppi_pkg::ST_E:
            begin
                mem_we          = 1'b1;
                mem_wdata.age   = clk_reg;
                mem_wdata.vel_x = vd_x_reg;
                mem_wdata.vel_y = vd_y_reg;
                mem_wdata.pos_x = ppi_pkg::sat32(34'($signed(rd_reg.pos_x)) +
                                                 34'(vdt_x_reg >>> 16));
                mem_wdata.pos_y = ppi_pkg::sat32(34'($signed(rd_reg.pos_y)) +
                                                 34'(vdt_y_reg >>> 16));
                res_next   = '{slot: idx_wide[4:0], alive: 1'b1, px: mem_wdata.pos_x,
                              py: mem_wdata.pos_y, full: 1'b0, last: (idx_reg == last_slot)};
                state_next = ppi_pkg::ST_EMIT;
            end

            // Hand the result to the output register
            ppi_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    if (res_reg.last)
                    begin
                        state_next = ppi_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ppi_pkg::ST_CHK;
                    end
                end
            end

            default:
            begin
                state_next = ppi_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppi_pkg::ST_IDLE;
            alive_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alive_reg     <= alive_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        idx_reg    <= idx_next;
        res_reg    <= res_next;
        clk_reg    <= clk_next;
        retire_reg <= retire_next;
        adt_x_reg  <= adt_x_next;
        adt_y_reg  <= adt_y_next;
        v_x_reg    <= v_x_next;
        v_y_reg    <= v_y_next;
        vdp_x_reg  <= vdp_x_next;
        vdp_y_reg  <= vdp_y_next;
        vd_x_reg   <= vd_x_next;
        vd_y_reg   <= vd_y_next;
        vdt_x_reg  <= vdt_x_next;
        vdt_y_reg  <= vdt_y_next;
        out_reg    <= out_next;
    end

    // Slot memory: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= mem_wdata;
        end
        rd_reg <= mem[idx_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_reg.py, out_reg.px, out_reg.slot};
    assign m_tuser  = {out_reg.full, out_reg.alive};
    assign m_tlast  = out_reg.last;

endmodule

`default_nettype wire

### src/particle_pool_integrator_top.sv
// Sequence: a spawn word is popped, then the slots are scanned in order for the lowest
// free one before its result is emitted. A tick gives one result per active slot:
// a dead slot goes from check to emit, a live one through check, read, A, B, C, D and
// E (a retiring one through check, read, A and B). Stalls on m_tready hold the emit state.
// Throughput: one command at a time; a two-word queue takes new input meanwhile.
// Reset (rst_n, async low): all slots free, damping 1.0, all slots active.
// ----------------------------------------------------------------------------
// particle_pool_integrator_top
// Particle slot pool with fixed-point Euler integration per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_pool_integrator_top
#(
    parameter int PARTICLE_SLOTS = ppi_pkg::PARTICLE_SLOTS_DEF
)
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [ppi_pkg::IN_DATA_W-1:0]      s_tdata,  // pos_x,pos_y,vel_x,vel_y,acc_x,acc_y,life_span,time_step
    input  wire                                s_tuser,  // opcode
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [ppi_pkg::OUT_DATA_W-1:0]     m_tdata,  // slot_index,out_pos_x,out_pos_y
    output logic [ppi_pkg::OUT_USER_W-1:0]     m_tuser,  // slot_alive,pool_full
    output logic                               m_tlast,
    input  wire                                wr_en,
    input  wire  [ppi_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  wire  [ppi_pkg::CFG_DATA_W-1:0]     wr_data
);

    localparam int IDX_W = (PARTICLE_SLOTS > 1) ? $clog2(PARTICLE_SLOTS) : 1;

    logic [15:0]      damping_reg;
    logic [5:0]       active_reg;
    logic [15:0]      damp_eff;
    logic [6:0]       act7;
    logic [6:0]       last7;
    logic [IDX_W-1:0] last_slot;

    logic             cmd_valid;
    ppi_pkg::cmd_t    cmd;
    logic             cmd_pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_reg <= ppi_pkg::DAMP_ONE;
            active_reg  <= ppi_pkg::ACTIVE_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ppi_pkg::REG_DAMPING: damping_reg <= wr_data;
                ppi_pkg::REG_ACTIVE:  active_reg  <= wr_data[5:0];
                default:              ;
            endcase
        end
    end

    // Clamp damping to one and the slot count to the pool
    always_comb
    begin
        damp_eff = (damping_reg > ppi_pkg::DAMP_ONE) ? ppi_pkg::DAMP_ONE : damping_reg;
        act7     = {1'b0, active_reg};
        if (act7 == 7'd0)
            last7 = 7'd0;
        else if (act7 > 7'(PARTICLE_SLOTS))
            last7 = 7'(PARTICLE_SLOTS - 1);
        else
            last7 = act7 - 7'd1;
        last_slot = last7[IDX_W-1:0];
    end

    ppi_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    ppi_back #(.PARTICLE_SLOTS(PARTICLE_SLOTS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .damp_eff  (damp_eff),
        .last_slot (last_slot),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
